### rtl/cbez_pkg.sv
`default_nettype none

package cbez_pkg;

  // default widths of the coordinates and of the curve parameter fraction
  localparam int COORD_BITS_DEF  = 16;
  localparam int T_FRAC_BITS_DEF = 16;

  // curve shape
  localparam int NUM_POINTS = 4;
  localparam int NUM_AXES   = 3;

  // configuration port
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_IDX_BITS  = 2;

  // what an input transaction asks for
  typedef enum logic {
    CMD_POSITION = 1'b0,
    CMD_TANGENT  = 1'b1
  } cmd_t;

endpackage

`default_nettype wire

### rtl/cubic_bezier_point_tangent_eval.sv
// Cubic Bezier curve evaluator, position or first derivative, by de Casteljau.
// Control points 0..3 are written over the cfg_ APB port at byte addresses 0, 8,
// 16 and 24; each holds signed x, y, z of COORD_BITS bits, x in the lowest bits.
// Input transactions (in_) carry t in unsigned fixed point with T_FRAC_BITS
// fraction bits in in_tdata; values above one are taken as one. in_tuser picks
// position (0) or tangent (1). Each input gives one result transaction (out_)
// with x, y, z of COORD_BITS+3 bits in out_tdata.
// The edge that accepts an input loads the first of six register stages (three
// interpolation levels, each a multiply stage and an accumulate stage); the
// result shows on out_tvalid once it reaches the last, the output register.
// One transaction per cycle is sustained while the receiver takes results; the
// cost is 18 multipliers of about (COORD_BITS+4) x (T_FRAC_BITS+2) bits.
// When the receiver stalls, the result is held in the output register and the
// stages behind it keep filling until each holds an item; in_tready falls only
// once the stage right behind the input is occupied and cannot move.
// Reset clears every stage valid bit and sets all four control points to zero.
// Control points are to be written only while no transaction is in flight.
`default_nettype none

module cubic_bezier_point_tangent_eval
  import cbez_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF,
  localparam int OB    = COORD_BITS + 3,
  localparam int IN_W  = ((T_FRAC_BITS + 1 + 7) / 8) * 8,
  localparam int OUT_W = ((3 * OB + 7) / 8) * 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // input channel
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [IN_W-1:0]          in_tdata,   // param_t
  input  wire logic                     in_tuser,   // cmd
  // result channel
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [OUT_W-1:0]              out_tdata,  // out_x, out_y, out_z
  // configuration port
  input  wire logic                     cfg_psel,
  input  wire logic                     cfg_penable,
  input  wire logic                     cfg_pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0]      cfg_prdata,
  output logic                          cfg_pready
);

  localparam int CB = COORD_BITS;
  localparam int TB = T_FRAC_BITS;
  localparam int RW = NUM_AXES * CB;
  localparam int DW = OB + 1;
  localparam int PW = OB + TB + 3;
  localparam logic [TB:0] T_ONE = {1'b1, {TB{1'b0}}};

  // control point registers
  logic [RW-1:0] point_r [NUM_POINTS];
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic cfg_wr;

  assign cfg_idx    = cfg_paddr[CFG_ADDR_BITS-1 -: CFG_IDX_BITS];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = CFG_DATA_BITS'(point_r[cfg_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        point_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      point_r[cfg_idx] <= cfg_pwdata[RW-1:0];
    end
  end

  // stage registers
  logic              s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, out_vld_r;
  logic [TB:0]       s1_t_r, s2_t_r, s3_t_r, s4_t_r;
  logic signed [OB-1:0] s1_a_r [NUM_AXES][3];
  logic signed [PW-1:0] s1_p_r [NUM_AXES][3];
  logic signed [OB-1:0] s2_v_r [NUM_AXES][3];
  logic signed [OB-1:0] s3_a_r [NUM_AXES][2];
  logic signed [PW-1:0] s3_p_r [NUM_AXES][2];
  logic signed [OB-1:0] s4_v_r [NUM_AXES][2];
  logic signed [OB-1:0] s5_a_r [NUM_AXES];
  logic signed [PW-1:0] s5_p_r [NUM_AXES];
  logic signed [OB-1:0] out_v_r [NUM_AXES];

  logic signed [OB-1:0] s1_a_nxt [NUM_AXES][3];
  logic signed [PW-1:0] s1_p_nxt [NUM_AXES][3];
  logic signed [OB-1:0] s2_v_nxt [NUM_AXES][3];
  logic signed [OB-1:0] s3_a_nxt [NUM_AXES][2];
  logic signed [PW-1:0] s3_p_nxt [NUM_AXES][2];
  logic signed [OB-1:0] s4_v_nxt [NUM_AXES][2];
  logic signed [OB-1:0] s5_a_nxt [NUM_AXES];
  logic signed [PW-1:0] s5_p_nxt [NUM_AXES];
  logic signed [OB-1:0] out_v_nxt [NUM_AXES];
  logic [TB:0]          s1_t_nxt;

  // per-stage advance, a stage moves when it is empty or its successor moves
  logic en1, en2, en3, en4, en5, en6;

  always_comb begin
    en6 = !out_vld_r || out_tready;
    en5 = !s5_vld_r || en6;
    en4 = !s4_vld_r || en5;
    en3 = !s3_vld_r || en4;
    en2 = !s2_vld_r || en3;
    en1 = !s1_vld_r || en2;
  end

  assign in_tready = en1;

  // a + floor((b - a) * t / one), the product part
  function automatic logic signed [PW-1:0] lerp_mul(logic signed [OB-1:0] a,
                                                    logic signed [OB-1:0] b,
                                                    logic [TB:0] t);
    logic signed [DW-1:0] d;
    logic signed [TB+1:0] ts;
    d  = DW'(b) - DW'(a);
    ts = $signed({1'b0, t});
    return PW'(d) * PW'(ts);
  endfunction

  // the accumulate part, floor shift of the product then add
  function automatic logic signed [OB-1:0] lerp_add(logic signed [OB-1:0] a,
                                                    logic signed [PW-1:0] p);
    logic signed [PW-1:0] sh;
    logic signed [DW-1:0] sum;
    sh  = p >>> TB;
    sum = DW'(a) + $signed(sh[DW-1:0]);
    return $signed(sum[OB-1:0]);
  endfunction

  // first level: products on the points, or the scaled differences for a tangent
  always_comb begin
    logic [TB:0]          t_raw;
    logic signed [CB-1:0] c0, c1;
    logic signed [DW-1:0] d, d3;
    t_raw    = in_tdata[TB:0];
    s1_t_nxt = (t_raw > T_ONE) ? T_ONE : t_raw;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      for (int j = 0; j < 3; j++) begin
        c0 = $signed(point_r[j][ax*CB +: CB]);
        c1 = $signed(point_r[j+1][ax*CB +: CB]);
        d  = DW'(c1) - DW'(c0);
        d3 = (d <<< 1) + d;
        if (cmd_t'(in_tuser) == CMD_TANGENT) begin
          s1_a_nxt[ax][j] = OB'(d3);
          s1_p_nxt[ax][j] = '0;
        end else begin
          s1_a_nxt[ax][j] = OB'(c0);
          s1_p_nxt[ax][j] = lerp_mul(OB'(c0), OB'(c1), s1_t_nxt);
        end
      end
    end
  end

  // remaining levels
  always_comb begin
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      for (int j = 0; j < 3; j++) begin
        s2_v_nxt[ax][j] = lerp_add(s1_a_r[ax][j], s1_p_r[ax][j]);
      end
      for (int j = 0; j < 2; j++) begin
        s3_a_nxt[ax][j] = s2_v_r[ax][j];
        s3_p_nxt[ax][j] = lerp_mul(s2_v_r[ax][j], s2_v_r[ax][j+1], s2_t_r);
        s4_v_nxt[ax][j] = lerp_add(s3_a_r[ax][j], s3_p_r[ax][j]);
      end
      s5_a_nxt[ax]  = s4_v_r[ax][0];
      s5_p_nxt[ax]  = lerp_mul(s4_v_r[ax][0], s4_v_r[ax][1], s4_t_r);
      out_v_nxt[ax] = lerp_add(s5_a_r[ax], s5_p_r[ax]);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (en1) s1_vld_r  <= in_tvalid;
      if (en2) s2_vld_r  <= s1_vld_r;
      if (en3) s3_vld_r  <= s2_vld_r;
      if (en4) s4_vld_r  <= s3_vld_r;
      if (en5) s5_vld_r  <= s4_vld_r;
      if (en6) out_vld_r <= s5_vld_r;
    end
  end

  // payload moves along with its valid bit
  always_ff @(posedge clk) begin
    if (en1 && in_tvalid) begin
      s1_t_r <= s1_t_nxt;
      s1_a_r <= s1_a_nxt;
      s1_p_r <= s1_p_nxt;
    end
    if (en2 && s1_vld_r) begin
      s2_t_r <= s1_t_r;
      s2_v_r <= s2_v_nxt;
    end
    if (en3 && s2_vld_r) begin
      s3_t_r <= s2_t_r;
      s3_a_r <= s3_a_nxt;
      s3_p_r <= s3_p_nxt;
    end
    if (en4 && s3_vld_r) begin
      s4_t_r <= s3_t_r;
      s4_v_r <= s4_v_nxt;
    end
    if (en5 && s4_vld_r) begin
      s5_a_r <= s5_a_nxt;
      s5_p_r <= s5_p_nxt;
    end
    if (en6 && s5_vld_r) begin
      out_v_r <= out_v_nxt;
    end
  end

  // result packing, x in the lowest bits
  assign out_tvalid = out_vld_r;

  always_comb begin
    out_tdata = '0;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      out_tdata[ax*OB +: OB] = out_v_r[ax];
    end
  end

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // an item in the last stage reaches the output when it may advance
  a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s5_vld_r && en6) |=> out_tvalid)
    else $error("item lost between last stage and output");

  // a receiver that takes results never blocks the input side
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while the output drains");

  // a configuration write lands in the addressed control point
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> point_r[$past(cfg_idx)] == $past(cfg_pwdata[RW-1:0]))
    else $error("control point write not stored");

endmodule

`default_nettype wire
